### hdl/line_pixel_rasterizer_unit_defines.svh
// Assertion macros for the line pixel rasterizer checker.
`ifndef LINE_PIXEL_RASTERIZER_UNIT_DEFINES_SVH
`define LINE_PIXEL_RASTERIZER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define LPR_ASSERT_NOW(name, cond_a, cond_b) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_b)) \
        else $error("lpr same-cycle check failed");

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define LPR_ASSERT_NEXT(name, cond_a, cond_b) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_b)) \
        else $error("lpr next-cycle check failed");

`endif

### hdl/lpr_pkg.sv
// Types and constants of the line pixel rasterizer.
package lpr_pkg;

    localparam int DATA_BITS = 16;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [1:0] STEP_NONE  = 2'd0;
    localparam logic [1:0] STEP_PLUS  = 2'd1;
    localparam logic [1:0] STEP_MINUS = 2'd3;

    typedef struct packed {
        logic                 opcode;
        logic [DATA_BITS-1:0] start_x;
        logic [DATA_BITS-1:0] start_y;
        logic [DATA_BITS-1:0] end_x;
        logic [DATA_BITS-1:0] end_y;
        logic [DATA_BITS-1:0] pixel_colour;
    } line_cmd_t;

    typedef struct packed {
        logic                 emit;
        logic [DATA_BITS-1:0] pixel_x;
        logic [DATA_BITS-1:0] pixel_y;
        logic [DATA_BITS-1:0] out_colour;
        logic                 last_pixel;
    } pixel_word_t;

    typedef struct packed {
        logic load;
        logic step;
    } stepper_ctrl_t;

endpackage

### hdl/lpr_channels.sv
// Valid/ready channel interfaces for line commands and pixel words.
interface lpr_cmd_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [lpr_pkg::DATA_BITS-1:0] start_x;
    logic [lpr_pkg::DATA_BITS-1:0] start_y;
    logic [lpr_pkg::DATA_BITS-1:0] end_x;
    logic [lpr_pkg::DATA_BITS-1:0] end_y;
    logic [lpr_pkg::DATA_BITS-1:0] pixel_colour;

    modport source (output valid, output opcode, output start_x, output start_y,
                    output end_x, output end_y, output pixel_colour, input ready);
    modport sink (input valid, input opcode, input start_x, input start_y,
                  input end_x, input end_y, input pixel_colour, output ready);
endinterface

interface lpr_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [lpr_pkg::DATA_BITS-1:0] pixel_x;
    logic [lpr_pkg::DATA_BITS-1:0] pixel_y;
    logic [lpr_pkg::DATA_BITS-1:0] out_colour;
    logic                          last_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output out_colour,
                    output last_pixel, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, input out_colour,
                  input last_pixel, output ready);
endinterface

### hdl/lpr_stepper.sv
// Line state registers and combinational Bresenham step logic.
module lpr_stepper #(
    parameter int COORD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lpr_pkg::stepper_ctrl_t ctrl,
    input  lpr_pkg::line_cmd_t    cmd,
    output lpr_pkg::pixel_word_t  result
);
    import lpr_pkg::*;

    localparam int ERR_BITS = COORD_BITS + 1;

    logic                  active_reg, active_next;
    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [1:0]            col_dir_reg, col_dir_next;
    logic [1:0]            row_dir_reg, row_dir_next;
    logic [COORD_BITS-1:0] delta_col_reg, delta_col_next;
    logic [COORD_BITS-1:0] delta_row_reg, delta_row_next;
    logic [COORD_BITS-1:0] major_reg, major_next;
    logic [ERR_BITS-1:0]   col_err_reg, col_err_next;
    logic [ERR_BITS-1:0]   row_err_reg, row_err_next;
    logic [ERR_BITS-1:0]   count_reg, count_next;
    logic [DATA_BITS-1:0]  colour_reg, colour_next;

    logic [COORD_BITS-1:0] sx, sy, ex, ey;
    logic [COORD_BITS-1:0] dx, dy;
    logic [1:0]            dir_x, dir_y;
    logic [ERR_BITS-1:0]   col_sum, row_sum, major_ext;
    logic                  is_last;

    assign sx = cmd.start_x[COORD_BITS-1:0];
    assign sy = cmd.start_y[COORD_BITS-1:0];
    assign ex = cmd.end_x[COORD_BITS-1:0];
    assign ey = cmd.end_y[COORD_BITS-1:0];

    // Per-axis absolute delta and direction code for a load.
    always_comb
    begin
        if (ex > sx)
        begin
            dx    = ex - sx;
            dir_x = STEP_PLUS;
        end
        else if (ex == sx)
        begin
            dx    = '0;
            dir_x = STEP_NONE;
        end
        else
        begin
            dx    = sx - ex;
            dir_x = STEP_MINUS;
        end
        if (ey > sy)
        begin
            dy    = ey - sy;
            dir_y = STEP_PLUS;
        end
        else if (ey == sy)
        begin
            dy    = '0;
            dir_y = STEP_NONE;
        end
        else
        begin
            dy    = sy - ey;
            dir_y = STEP_MINUS;
        end
    end

    assign major_ext = ERR_BITS'(major_reg);
    assign col_sum   = col_err_reg + ERR_BITS'(delta_col_reg);
    assign row_sum   = row_err_reg + ERR_BITS'(delta_row_reg);
    assign is_last   = (count_reg == major_ext + ERR_BITS'(1));

    always_comb
    begin
        active_next    = active_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        col_dir_next   = col_dir_reg;
        row_dir_next   = row_dir_reg;
        delta_col_next = delta_col_reg;
        delta_row_next = delta_row_reg;
        major_next     = major_reg;
        col_err_next   = col_err_reg;
        row_err_next   = row_err_reg;
        count_next     = count_reg;
        colour_next    = colour_reg;
        if (ctrl.load)
        begin
            active_next    = 1'b1;
            col_next       = sx;
            row_next       = sy;
            col_dir_next   = dir_x;
            row_dir_next   = dir_y;
            delta_col_next = dx;
            delta_row_next = dy;
            major_next     = (dx > dy) ? dx : dy;
            col_err_next   = '0;
            row_err_next   = '0;
            count_next     = '0;
            colour_next    = cmd.pixel_colour;
        end
        else if (ctrl.step && active_reg)
        begin
            col_err_next = col_sum;
            row_err_next = row_sum;
            if (col_sum > major_ext)
            begin
                col_err_next = col_sum - major_ext;
                case (col_dir_reg)
                    STEP_PLUS:  col_next = col_reg + COORD_BITS'(1);
                    STEP_MINUS: col_next = col_reg - COORD_BITS'(1);
                    default:    col_next = col_reg;
                endcase
            end
            if (row_sum > major_ext)
            begin
                row_err_next = row_sum - major_ext;
                case (row_dir_reg)
                    STEP_PLUS:  row_next = row_reg + COORD_BITS'(1);
                    STEP_MINUS: row_next = row_reg - COORD_BITS'(1);
                    default:    row_next = row_reg;
                endcase
            end
            count_next = count_reg + ERR_BITS'(1);
            if (is_last)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            col_dir_reg   <= STEP_NONE;
            row_dir_reg   <= STEP_NONE;
            delta_col_reg <= '0;
            delta_row_reg <= '0;
            major_reg     <= '0;
            col_err_reg   <= '0;
            row_err_reg   <= '0;
            count_reg     <= '0;
            colour_reg    <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            col_dir_reg   <= col_dir_next;
            row_dir_reg   <= row_dir_next;
            delta_col_reg <= delta_col_next;
            delta_row_reg <= delta_row_next;
            major_reg     <= major_next;
            col_err_reg   <= col_err_next;
            row_err_reg   <= row_err_next;
            count_reg     <= count_next;
            colour_reg    <= colour_next;
        end
    end

    assign result.emit       = ctrl.step && active_reg;
    assign result.pixel_x    = DATA_BITS'(col_reg);
    assign result.pixel_y    = DATA_BITS'(row_reg);
    assign result.out_colour = colour_reg;
    assign result.last_pixel = is_last;

endmodule

### hdl/line_pixel_rasterizer_unit.sv
// A step word passes the input register, then the result register as a pixel.
// Throughput: one command word per cycle unless the pixel sink stalls; the
// stepper updates its line state in the same cycle it forms a pixel, so steps
// run back to back. A load or a step with no active line gives no pixel word.
// Reset (rst_n low, asynchronous) clears the line state, so no line is active.
// No clearing pass: the block is ready as soon as reset is released.
module line_pixel_rasterizer_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    lpr_cmd_if.sink     line_in,
    lpr_pixel_if.source pixel_out
);
    import lpr_pkg::*;

    // Input register: one command word waiting for the stepper.
    logic          in_valid_reg;
    line_cmd_t     in_word_reg;

    // Result register: one pixel word waiting for the sink.
    logic          out_valid_reg;
    pixel_word_t   out_word_reg;

    logic          advance;
    stepper_ctrl_t ctrl;
    pixel_word_t   result;

    // Process the held command when the result slot is free or draining now.
    // Every command takes the slot, so a load never slips past a held pixel.
    assign advance       = in_valid_reg && (!out_valid_reg || pixel_out.ready);
    assign line_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (line_in.ready)
        begin
            in_valid_reg <= line_in.valid;
        end
    end

    // Payload needs no reset; capture on every accepted word.
    always_ff @(posedge clk)
    begin
        if (line_in.valid && line_in.ready)
        begin
            in_word_reg.opcode       <= line_in.opcode;
            in_word_reg.start_x      <= line_in.start_x;
            in_word_reg.start_y      <= line_in.start_y;
            in_word_reg.end_x        <= line_in.end_x;
            in_word_reg.end_y        <= line_in.end_y;
            in_word_reg.pixel_colour <= line_in.pixel_colour;
        end
    end

    assign ctrl.load = advance && (in_word_reg.opcode == OP_LOAD);
    assign ctrl.step = advance && (in_word_reg.opcode == OP_STEP);

    lpr_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .cmd    (in_word_reg),
        .result (result)
    );

    // Refill the result slot on advance; otherwise drop it once it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= result.emit;
        end
        else if (pixel_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.emit)
        begin
            out_word_reg <= result;
        end
    end

    assign pixel_out.valid      = out_valid_reg;
    assign pixel_out.pixel_x    = out_word_reg.pixel_x;
    assign pixel_out.pixel_y    = out_word_reg.pixel_y;
    assign pixel_out.out_colour = out_word_reg.out_colour;
    assign pixel_out.last_pixel = out_word_reg.last_pixel;

endmodule

### hdl/lpr_checker.sv
// Port-level checker for the line pixel rasterizer, with its bind.
`include "line_pixel_rasterizer_unit_defines.svh"

module lpr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [lpr_pkg::DATA_BITS-1:0] pixel_x,
    input logic [lpr_pkg::DATA_BITS-1:0] pixel_y,
    input logic [lpr_pkg::DATA_BITS-1:0] out_colour,
    input logic                          last_pixel
);
    // A stalled pixel word holds its contents.
    `LPR_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(out_colour) && $stable(last_pixel))

    // Input back-pressure only comes from a stalled pixel word.
    `LPR_ASSERT_NOW(a_backpressure_cause, !in_ready, out_valid && !out_ready)

    // A draining output always frees the input side.
    `LPR_ASSERT_NOW(a_drain_frees_input, out_valid && out_ready, in_ready)

    // An idle input side with a free output leaves the input side ready.
    `LPR_ASSERT_NEXT(a_pipe_empties, !in_valid && in_ready && !out_valid, in_ready)

endmodule

bind line_pixel_rasterizer_unit lpr_checker u_lpr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (line_in.valid),
    .in_ready   (line_in.ready),
    .out_valid  (pixel_out.valid),
    .out_ready  (pixel_out.ready),
    .pixel_x    (pixel_out.pixel_x),
    .pixel_y    (pixel_out.pixel_y),
    .out_colour (pixel_out.out_colour),
    .last_pixel (pixel_out.last_pixel)
);
